FILE: rtl/core/mcsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcsf_pkg
// Shared types and constants of the memory change scan filter: item
// layouts, action codes and the control groups between its modules.
// ----------------------------------------------------------------------------
package mcsf_pkg;

  // action codes carried in the input tuser
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_COMPARE = 2'd1;
  localparam logic [1:0] ACT_UNREAD  = 2'd2;
  localparam logic [1:0] ACT_END     = 2'd3;

  // scan modes
  localparam logic MODE_CHANGED   = 1'b0;
  localparam logic MODE_UNCHANGED = 1'b1;

  // field widths fixed by the item formats
  localparam int ACT_W    = 2;
  localparam int AREA_W   = 2;
  localparam int OFS_W    = 8;
  localparam int WORD_W   = 64;
  localparam int HITS_W   = 11;
  localparam int REL_W    = 4;
  localparam int CFG_IDX_W = 3;

  // hit counter saturation value
  localparam logic [HITS_W-1:0] HIT_LIMIT = 11'd1024;

  // input tdata: area, word offset, word value, scan mode (low to high), padded
  typedef struct packed {
    logic [4:0]        pad;
    logic              scan_mode;
    logic [WORD_W-1:0] word_value;
    logic [OFS_W-1:0]  word_offset;
    logic [AREA_W-1:0] area_index;
  } in_item_t;

  // output tdata: address, area, old, new, pass hits, released (low to high)
  typedef struct packed {
    logic [6:0]        pad;
    logic [REL_W-1:0]  released_areas;
    logic [HITS_W-1:0] pass_hits;
    logic [WORD_W-1:0] new_value;
    logic [WORD_W-1:0] old_value;
    logic [AREA_W-1:0] hit_area;
    logic [WORD_W-1:0] hit_address;
  } out_item_t;

  localparam int IN_TDATA_W  = $bits(in_item_t);
  localparam int OUT_TDATA_W = $bits(out_item_t);

  // one-cycle update strobes for the area bookkeeping
  typedef struct packed {
    logic load_fresh;
    logic revive;
    logic drop;
    logic invalidate;
    logic end_pass;
  } area_op_t;

  // area status seen by the control: flag and base of the selected area, release mask of all areas
  typedef struct packed {
    logic              area_inv;
    logic [WORD_W-1:0] base;
    logic [REL_W-1:0]  rel_mask;
  } area_stat_t;

endpackage : mcsf_pkg
`default_nettype wire

FILE: rtl/core/mcsf_word_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcsf_word_mem
// Per-word storage: snapshot words and eliminated marks, each one
// synchronous memory with one write and one registered read port.
// ----------------------------------------------------------------------------
module mcsf_word_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic                       snap_we,
  input  wire logic [mcsf_pkg::WORD_W-1:0] snap_wdata,
  input  wire logic                       elim_we,
  input  wire logic                       elim_wdata,
  output logic      [mcsf_pkg::WORD_W-1:0] snap_rd,
  output logic                            elim_rd
);
  import mcsf_pkg::*;

  logic [WORD_W-1:0] snap_mem [DEPTH];
  logic              elim_mem [DEPTH];

  // snapshot words
  always_ff @(posedge clk) begin
    if (snap_we) begin
      snap_mem[wr_addr] <= snap_wdata;
    end
    if (rd_en) begin
      snap_rd <= snap_mem[rd_addr];
    end
  end

  // eliminated marks
  always_ff @(posedge clk) begin
    if (elim_we) begin
      elim_mem[wr_addr] <= elim_wdata;
    end
    if (rd_en) begin
      elim_rd <= elim_mem[rd_addr];
    end
  end

endmodule : mcsf_word_mem
`default_nettype wire

FILE: rtl/core/mcsf_area_ctl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mcsf_area_ctl
// Per-area bookkeeping: base address registers, invalid flags and
// live-word counts, with the release check for end of pass.
// ----------------------------------------------------------------------------
module mcsf_area_ctl #(
  parameter int AREAS          = 4,
  parameter int WORDS_PER_AREA = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mcsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mcsf_pkg::WORD_W-1:0]    cfg_data,
  input  wire logic [mcsf_pkg::AREA_W-1:0]    sel_area,
  input  wire mcsf_pkg::area_op_t             op,
  output mcsf_pkg::area_stat_t                stat
);
  import mcsf_pkg::*;

  localparam int AIW = (AREAS > 1) ? $clog2(AREAS) : 1;
  localparam int LW  = $clog2(WORDS_PER_AREA + 1);
  localparam logic [LW-1:0] LIVE_FULL = LW'(WORDS_PER_AREA);

  logic [WORD_W-1:0] bases_r [AREAS];
  logic [AREAS-1:0]  inv_r, inv_nxt;
  logic [LW-1:0]     live_r [AREAS];
  logic [LW-1:0]     live_nxt [AREAS];
  logic [AREAS-1:0]  rel_vec;
  logic [AREAS+REL_W-1:0] rel_ext;
  logic [AIW-1:0]    sidx;
  logic              sel_ok;

  assign sidx   = AIW'(sel_area);
  assign sel_ok = int'(sel_area) < AREAS;

  // areas that would be released now
  always_comb begin
    for (int a = 0; a < AREAS; a++) begin
      rel_vec[a] = !inv_r[a] && (live_r[a] == '0);
    end
  end
  assign rel_ext = {{REL_W{1'b0}}, rel_vec};

  // status of the selected area, with the release mask of all areas
  always_comb begin
    stat.area_inv = sel_ok ? inv_r[sidx] : 1'b1;
    stat.base     = bases_r[sidx];
    stat.rel_mask = rel_ext[REL_W-1:0];
  end

  // flag and count updates
  always_comb begin
    inv_nxt = inv_r;
    for (int a = 0; a < AREAS; a++) begin
      live_nxt[a] = live_r[a];
    end
    if (op.load_fresh && sel_ok) begin
      inv_nxt[sidx]  = 1'b0;
      live_nxt[sidx] = LIVE_FULL;
    end
    if (op.revive && sel_ok && (live_r[sidx] < LIVE_FULL)) begin
      live_nxt[sidx] = live_r[sidx] + 1'b1;
    end
    if (op.drop && sel_ok && (live_r[sidx] != '0)) begin
      live_nxt[sidx] = live_r[sidx] - 1'b1;
    end
    if (op.invalidate && sel_ok) begin
      inv_nxt[sidx] = 1'b1;
    end
    if (op.end_pass) begin
      inv_nxt = inv_r | rel_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= '1;
      for (int a = 0; a < AREAS; a++) begin
        live_r[a] <= '0;
      end
    end else begin
      inv_r <= inv_nxt;
      for (int a = 0; a < AREAS; a++) begin
        live_r[a] <= live_nxt[a];
      end
    end
  end

  // base address registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AREAS; a++) begin
        bases_r[a] <= '0;
      end
    end else if (cfg_we && (int'(cfg_index) < AREAS)) begin
      bases_r[AIW'(cfg_index)] <= cfg_data;
    end
  end

endmodule : mcsf_area_ctl
`default_nettype wire

FILE: rtl/core/memory_change_scan_filter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// memory_change_scan_filter_top
// Candidate filter over watched memory areas of 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per memory word read back (load, compare), or an area
//           unreadable / end-of-pass marker; the action code rides in tuser.
//   out_* : exactly one result item per input item, in order; tuser is the
//           hit flag. Bases of the areas are to be written on cfg_* while
//           the block is idle, a rule the block leaves to the user; cfg_ready is always high.
//   Each item is one read-modify-write of the snapshot and eliminated-mark
//   memories: read in the accept cycle, then decided and written back once
//   the result register is free, at the same edge that loads the result
//   register; no new item is accepted before that. A load that reopens an
//   invalid area then sweeps that area's eliminated marks, one word per
//   cycle, with in_tready low.
//   Reset marks every area invalid, zeroes the live counts, the hit
//   counter and the bases; the memories are not cleared.
//   The result register holds while out_tready is low; one more item can
//   be accepted and read meanwhile, and it completes once the register
//   frees.
// ----------------------------------------------------------------------------
module memory_change_scan_filter_top #(
  parameter int AREAS          = 4,
  parameter int WORDS_PER_AREA = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input items
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // area_index[1:0], word_offset[9:2], word_value[73:10], scan_mode[74]
  input  wire logic [mcsf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  wire logic [mcsf_pkg::ACT_W-1:0]       in_tuser,
  // result items
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // hit_address[63:0], hit_area[65:64], old_value[129:66],
  // new_value[193:130], pass_hits[204:194], released_areas[208:205]
  output logic [mcsf_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // hit[0]
  output logic                                  out_tuser,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mcsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mcsf_pkg::WORD_W-1:0]      cfg_data
);
  import mcsf_pkg::*;

  localparam int DEPTH = AREAS * WORDS_PER_AREA;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (WORDS_PER_AREA > 1) ? $clog2(WORDS_PER_AREA) : 1;
  localparam logic [CW-1:0] CLR_LAST = CW'(WORDS_PER_AREA - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0]        state_r, state_nxt;
  in_item_t          in_item, item_r;
  logic [ACT_W-1:0]  act_r;
  logic [CW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [HITS_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              out_hit_r, out_hit_nxt;

  logic              in_fire, slot_free, item_in_range, same, drop;
  logic              rd_en, snap_we, elim_we, elim_wdata, elim_rd;
  logic [AW-1:0]     rd_addr, wr_addr, item_addr, clr_addr;
  logic [WORD_W-1:0] snap_rd;
  area_op_t          op;
  area_stat_t        stat;

  function automatic logic [AW-1:0] word_addr(logic [AREA_W-1:0] area, int ofs);
    return AW'(int'(area) * WORDS_PER_AREA + ofs);
  endfunction

  assign in_item   = in_tdata;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // memory read issued at accept
  assign rd_en     = in_fire;
  assign rd_addr   = word_addr(in_item.area_index, int'(in_item.word_offset));
  assign item_addr = word_addr(item_r.area_index, int'(item_r.word_offset));
  assign clr_addr  = word_addr(item_r.area_index, int'(clr_cnt_r));

  assign item_in_range = (int'(item_r.area_index) < AREAS) &&
                         (int'(item_r.word_offset) < WORDS_PER_AREA);
  assign slot_free = !out_valid_r || out_tready;
  assign same      = (snap_rd == item_r.word_value);
  assign drop      = (item_r.scan_mode == MODE_UNCHANGED) ? !same : same;

  mcsf_word_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_word_mem (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .snap_we   (snap_we),
    .snap_wdata(item_r.word_value),
    .elim_we   (elim_we),
    .elim_wdata(elim_wdata),
    .snap_rd   (snap_rd),
    .elim_rd   (elim_rd)
  );

  mcsf_area_ctl #(
    .AREAS         (AREAS),
    .WORDS_PER_AREA(WORDS_PER_AREA)
  ) u_area_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .sel_area (item_r.area_index),
    .op       (op),
    .stat     (stat)
  );

  // sequencer: decide, write back, load the result register, run the mark sweep
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    hit_cnt_nxt   = hit_cnt_r;
    op            = '0;
    snap_we       = 1'b0;
    elim_we       = 1'b0;
    elim_wdata    = 1'b0;
    wr_addr       = item_addr;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_hit_nxt   = out_hit_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_hit_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
          unique case (act_r)
            ACT_LOAD: begin
              if (item_in_range) begin
                snap_we = 1'b1;
                if (stat.area_inv) begin
                  op.load_fresh = 1'b1;
                  clr_cnt_nxt   = '0;
                  state_nxt     = ST_CLEAR;
                end else if (elim_rd) begin
                  op.revive  = 1'b1;
                  elim_we    = 1'b1;
                  elim_wdata = 1'b0;
                end
              end
            end
            ACT_COMPARE: begin
              if (item_in_range && !stat.area_inv && !elim_rd) begin
                if (drop) begin
                  op.drop    = 1'b1;
                  elim_we    = 1'b1;
                  elim_wdata = 1'b1;
                end else begin
                  snap_we = 1'b1;
                  if (hit_cnt_r < HIT_LIMIT) begin
                    hit_cnt_nxt = hit_cnt_r + 1'b1;
                  end
                  out_hit_nxt              = 1'b1;
                  out_data_nxt.hit_address = stat.base +
                    {{(WORD_W-OFS_W-3){1'b0}}, item_r.word_offset, 3'b000};
                  out_data_nxt.hit_area    = item_r.area_index;
                  out_data_nxt.old_value   = snap_rd;
                  out_data_nxt.new_value   = item_r.word_value;
                end
              end
            end
            ACT_UNREAD: begin
              op.invalidate = 1'b1;
            end
            ACT_END: begin
              op.end_pass = 1'b1;
              out_data_nxt.released_areas = stat.rel_mask;
              hit_cnt_nxt = '0;
            end
          endcase
          out_data_nxt.pass_hits = (act_r == ACT_END) ? hit_cnt_r : hit_cnt_nxt;
        end
      end
      ST_CLEAR: begin
        elim_we    = 1'b1;
        elim_wdata = 1'b0;
        wr_addr    = clr_addr;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clr_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
      act_r  <= in_tuser;
    end
    out_data_r <= out_data_nxt;
    out_hit_r  <= out_hit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  // hit counter never exceeds its saturation value
  a_hit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    hit_cnt_r <= HIT_LIMIT)
    else $error("hit counter beyond its limit");

  // a hit result never carries a release mask
  a_hit_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_data_r.released_areas == '0))
    else $error("hit result with released areas");

  // reopening an area always starts the mark sweep
  a_fresh_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    op.load_fresh |=> (state_r == ST_CLEAR) && (clr_cnt_r == '0))
    else $error("area reopened without clearing sweep");

  // the sweep ends after its last word
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_cnt_r == CLR_LAST) |=> (state_r == ST_IDLE))
    else $error("clearing sweep overran");

endmodule : memory_change_scan_filter_top
`default_nettype wire
